/* rtl/tsma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsma_pkg: shared constants and types
// Widths, window lengths, reciprocal constants and register map of the
// triple moving-average alignment block.
// ----------------------------------------------------------------------------
package tsma_pkg;

  // Price and sum widths
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned HALF_W  = SUM_W / 2;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned PROD_W  = SUM_W + LEN_W;

  // Window lengths
  localparam int unsigned FAST_LEN = 20;
  localparam int unsigned MID_LEN  = 50;
  localparam int unsigned SLOW_LEN = 200;

  // Close history
  localparam int unsigned HIST_DEPTH = 256;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

  // Bar counter saturates at the largest warm-up length
  localparam int unsigned LIM_A      = (SLOW_LEN + 2 > MID_LEN + 1) ? SLOW_LEN + 2 : MID_LEN + 1;
  localparam int unsigned BARS_LIMIT = (LIM_A > FAST_LEN + 1) ? LIM_A : FAST_LEN + 1;
  localparam int unsigned BARS_W     = $clog2(BARS_LIMIT + 1);

  // Reciprocals for division by window length: floor(2^SUM_W / len)
  localparam logic [SUM_W-1:0] FAST_RECIP = SUM_W'((65'd1 << SUM_W) / FAST_LEN);
  localparam logic [SUM_W-1:0] MID_RECIP  = SUM_W'((65'd1 << SUM_W) / MID_LEN);
  localparam logic [SUM_W-1:0] SLOW_RECIP = SUM_W'((65'd1 << SUM_W) / SLOW_LEN);

  // Remainder after the estimated quotient stays below twice the length
  localparam int unsigned REM_W = LEN_W + 1;

  // Configuration port
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned REG_IX_W = PADDR_W - 2;
  localparam logic [REG_IX_W-1:0] REG_MARKER_OFFSET = REG_IX_W'(0);
  localparam int unsigned OFFSET_W = 16;
  localparam logic [OFFSET_W-1:0] MARKER_OFFSET_RESET = OFFSET_W'(50);

  // Stage loads of the constant divider
  typedef struct packed {
    logic pp;   // load partial products
    logic acc;  // load quotient estimate
    logic rem;  // load remainder
  } div_en_t;

endpackage

/* rtl/tsma_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsma_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered under read enable.
// ----------------------------------------------------------------------------
module tsma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tsma_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsma_div: pipelined division of a window sum by its length
// Reciprocal multiply in split partial products, then one remainder
// correction step. Three register stages, each loaded by its own enable.
// ----------------------------------------------------------------------------
module tsma_div (
  input  logic                          clk,
  input  tsma_pkg::div_en_t             en,
  input  logic [tsma_pkg::SUM_W-1:0]    x,
  input  logic [tsma_pkg::LEN_W-1:0]    divisor,
  input  logic [tsma_pkg::SUM_W-1:0]    recip,
  output logic [tsma_pkg::PRICE_W-1:0]  quot
);

  localparam int unsigned SW = tsma_pkg::SUM_W;
  localparam int unsigned HW = tsma_pkg::HALF_W;
  localparam int unsigned PW = 2 * SW;

  logic [SW-1:0]              pp_ll, pp_lh, pp_hl, pp_hh;
  logic [SW-1:0]              a_x, b_x, b_q;
  logic [PW-1:0]              prod;
  logic [SW-1:0]              diff;
  logic [tsma_pkg::REM_W-1:0] c_rem;
  logic [tsma_pkg::PRICE_W-1:0] c_q;

  // Partial products of x and the reciprocal, each half by half
  always_ff @(posedge clk) begin
    if (en.pp) begin
      pp_ll <= SW'(x[HW-1:0])  * SW'(recip[HW-1:0]);
      pp_lh <= SW'(x[HW-1:0])  * SW'(recip[SW-1:HW]);
      pp_hl <= SW'(x[SW-1:HW]) * SW'(recip[HW-1:0]);
      pp_hh <= SW'(x[SW-1:HW]) * SW'(recip[SW-1:HW]);
      a_x   <= x;
    end
  end

  // Sum the partial products; the top half is the quotient estimate
  assign prod = PW'(pp_ll) + ((PW'(pp_lh) + PW'(pp_hl)) << HW) + (PW'(pp_hh) << SW);

  always_ff @(posedge clk) begin
    if (en.acc) begin
      b_q <= prod[PW-1:SW];
      b_x <= a_x;
    end
  end

  // Estimate is the quotient or one below it; keep the remainder
  assign diff = b_x - SW'(b_q * SW'(divisor));

  always_ff @(posedge clk) begin
    if (en.rem) begin
      c_rem <= diff[tsma_pkg::REM_W-1:0];
      c_q   <= b_q[tsma_pkg::PRICE_W-1:0];
    end
  end

  // Correct the estimate by one where the remainder reaches the divisor
  assign quot = c_q + tsma_pkg::PRICE_W'(c_rem >= tsma_pkg::REM_W'(divisor));

endmodule

/* rtl/triple_sma_alignment_signal_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_sma_alignment_signal_top: moving-average alignment buy signal
// One price bar in, one result out: fast, mid and slow averages, a buy flag
// where fast > mid > slow newly holds, and the marker price below the low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one bar per item, oldest first:
//   close_price and low_price. Output channel (out_valid/out_ready) returns
//   one result item per bar, in order.
//   Throughput: one bar per cycle while the output is not stalled. Each bar
//   makes one write and three reads of the close history, one RAM copy per
//   window, and passes a six-stage pipeline: history read, window sums,
//   products, ordering and quotient estimate, remainder, output register.
//   Stall: each stage holds only while the stage after it is full and held,
//   so empty stages keep taking bars while a result waits at the output.
//   Reset: rst clears the pipeline, bar count, write pointer, window sums,
//   the stored ordering flag and sets marker_offset to 50. The history is
//   not cleared; entries read before they are written are not used.
//   Configuration: marker_offset at byte address 0 over the APB port, to be
//   written by the user only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module triple_sma_alignment_signal_top (
  input  logic                             clk,
  input  logic                             rst,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tsma_pkg::PADDR_W-1:0]     paddr,
  input  logic [tsma_pkg::PDATA_W-1:0]     pwdata,
  output logic [tsma_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  // bar input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tsma_pkg::PRICE_W-1:0]     close_price,
  input  logic [tsma_pkg::PRICE_W-1:0]     low_price,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tsma_pkg::PRICE_W-1:0]     fast_average,
  output logic [tsma_pkg::PRICE_W-1:0]     mid_average,
  output logic [tsma_pkg::PRICE_W-1:0]     slow_average,
  output logic                             buy_signal,
  output logic [tsma_pkg::PRICE_W-1:0]     marker_price
);

  localparam int unsigned PW = tsma_pkg::PRICE_W;
  localparam int unsigned SW = tsma_pkg::SUM_W;
  localparam int unsigned AW = tsma_pkg::HIST_AW;
  localparam int unsigned BW = tsma_pkg::BARS_W;
  localparam int unsigned LW = tsma_pkg::LEN_W;
  localparam int unsigned XW = tsma_pkg::PROD_W;

  typedef struct packed {
    logic fast;
    logic mid;
    logic slow;
  } win_t;

  // Step back a given number of entries in the circular history
  function automatic logic [AW-1:0] hist_back(input logic [AW-1:0] pos,
                                              input logic [AW-1:0] steps);
    logic [AW-1:0] res;
    if (pos >= steps) begin
      res = pos - steps;
    end else begin
      res = pos + (AW'(tsma_pkg::HIST_DEPTH) - steps);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [tsma_pkg::OFFSET_W-1:0] marker_offset;
  logic [tsma_pkg::REG_IX_W-1:0] reg_ix;

  assign pready = 1'b1;
  assign reg_ix = paddr[tsma_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_offset <= tsma_pkg::MARKER_OFFSET_RESET;
    end else if (psel && penable && pwrite && pready
                 && reg_ix == tsma_pkg::REG_MARKER_OFFSET) begin
      marker_offset <= pwdata[tsma_pkg::OFFSET_W-1:0];
    end
  end

  assign prdata = (reg_ix == tsma_pkg::REG_MARKER_OFFSET)
                  ? tsma_pkg::PDATA_W'(marker_offset) : '0;

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic en1, en2, en3, en4, en5, en6;

  assign rdy6 = !out_valid || out_ready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  assign en1 = in_valid && rdy1;
  assign en2 = v1 && rdy2;
  assign en3 = v2 && rdy3;
  assign en4 = v3 && rdy4;
  assign en5 = v4 && rdy5;
  assign en6 = v5 && rdy6;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) out_valid <= v5;
    end
  end

  // --------------------------------------------------------------------------
  // Accept: history write, three history reads, bar count
  // --------------------------------------------------------------------------
  logic [AW-1:0] wp, wp_next;
  logic [BW-1:0] bars_seen, bars_next;
  logic [AW-1:0] rd_fast, rd_mid, rd_slow;
  win_t          drop_now, ok_now;

  assign wp_next   = (wp == AW'(tsma_pkg::HIST_DEPTH - 1)) ? '0 : wp + AW'(1);
  assign bars_next = (bars_seen < BW'(tsma_pkg::BARS_LIMIT)) ? bars_seen + BW'(1) : bars_seen;

  assign rd_fast = hist_back(wp, AW'(tsma_pkg::FAST_LEN));
  assign rd_mid  = hist_back(wp, AW'(tsma_pkg::MID_LEN));
  assign rd_slow = hist_back(wp, AW'(tsma_pkg::SLOW_LEN));

  // Drop the oldest close once a window is full
  assign drop_now.fast = bars_seen >= BW'(tsma_pkg::FAST_LEN);
  assign drop_now.mid  = bars_seen >= BW'(tsma_pkg::MID_LEN);
  assign drop_now.slow = bars_seen >= BW'(tsma_pkg::SLOW_LEN);

  // Averages are shown once enough bars have arrived
  assign ok_now.fast = bars_next > BW'(tsma_pkg::FAST_LEN);
  assign ok_now.mid  = ok_now.fast && bars_next > BW'(tsma_pkg::MID_LEN);
  assign ok_now.slow = ok_now.mid && bars_next >= BW'(tsma_pkg::SLOW_LEN + 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      bars_seen <= '0;
    end else if (en1) begin
      wp        <= wp_next;
      bars_seen <= bars_next;
    end
  end

  logic [PW-1:0] fast_old, mid_old, slow_old;

  tsma_ram #(.WIDTH(PW), .DEPTH(tsma_pkg::HIST_DEPTH)) u_hist_fast (
    .clk(clk), .we(en1), .waddr(wp), .wdata(close_price),
    .re(en1), .raddr(rd_fast), .rdata(fast_old)
  );

  tsma_ram #(.WIDTH(PW), .DEPTH(tsma_pkg::HIST_DEPTH)) u_hist_mid (
    .clk(clk), .we(en1), .waddr(wp), .wdata(close_price),
    .re(en1), .raddr(rd_mid), .rdata(mid_old)
  );

  tsma_ram #(.WIDTH(PW), .DEPTH(tsma_pkg::HIST_DEPTH)) u_hist_slow (
    .clk(clk), .we(en1), .waddr(wp), .wdata(close_price),
    .re(en1), .raddr(rd_slow), .rdata(slow_old)
  );

  // Stage 1 payload
  logic [PW-1:0] s1_close, s1_low;
  win_t          s1_drop, s1_ok;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_close <= close_price;
      s1_low   <= low_price;
      s1_drop  <= drop_now;
      s1_ok    <= ok_now;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: slide the window sums (the sums are this stage's payload)
  // --------------------------------------------------------------------------
  logic [SW-1:0] fast_sum, mid_sum, slow_sum;
  logic [SW-1:0] fast_sum_next, mid_sum_next, slow_sum_next;
  logic [PW-1:0] s2_low;
  win_t          s2_ok;

  assign fast_sum_next = fast_sum - (s1_drop.fast ? SW'(fast_old) : '0) + SW'(s1_close);
  assign mid_sum_next  = mid_sum  - (s1_drop.mid  ? SW'(mid_old)  : '0) + SW'(s1_close);
  assign slow_sum_next = slow_sum - (s1_drop.slow ? SW'(slow_old) : '0) + SW'(s1_close);

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_sum <= '0;
      mid_sum  <= '0;
      slow_sum <= '0;
    end else if (en2) begin
      fast_sum <= fast_sum_next;
      mid_sum  <= mid_sum_next;
      slow_sum <= slow_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_low <= s1_low;
      s2_ok  <= s1_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: cross products for the exact ordering test
  // --------------------------------------------------------------------------
  logic [XW-1:0] p_fm, p_mf, p_ms, p_sm;
  logic [PW-1:0] s3_low;
  win_t          s3_ok;

  always_ff @(posedge clk) begin
    if (en3) begin
      p_fm   <= XW'(fast_sum) * XW'(tsma_pkg::MID_LEN);
      p_mf   <= XW'(mid_sum)  * XW'(tsma_pkg::FAST_LEN);
      p_ms   <= XW'(mid_sum)  * XW'(tsma_pkg::SLOW_LEN);
      p_sm   <= XW'(slow_sum) * XW'(tsma_pkg::MID_LEN);
      s3_low <= s2_low;
      s3_ok  <= s2_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: ordering, buy flag, marker price
  // --------------------------------------------------------------------------
  logic          order_now, signal_now, prev_order;
  logic [PW-1:0] marker_now;
  logic          s4_signal;
  logic [PW-1:0] s4_marker;
  win_t          s4_ok;

  assign order_now  = (p_fm > p_mf) && (p_ms > p_sm);
  assign signal_now = s3_ok.slow && order_now && !prev_order;

  // Place the marker below the low on a buy flag, else zero; clamp at zero
  always_comb begin
    marker_now = '0;
    if (signal_now && s3_low > PW'(marker_offset)) begin
      marker_now = s3_low - PW'(marker_offset);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_order <= 1'b0;
    end else if (en4) begin
      prev_order <= order_now;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_signal <= signal_now;
      s4_marker <= marker_now;
      s4_ok     <= s3_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 to 5: divide each sum by its length
  // --------------------------------------------------------------------------
  tsma_pkg::div_en_t div_en;
  logic [PW-1:0]     fast_q, mid_q, slow_q;

  assign div_en.pp  = en3;
  assign div_en.acc = en4;
  assign div_en.rem = en5;

  tsma_div u_div_fast (
    .clk(clk), .en(div_en), .x(fast_sum), .divisor(LW'(tsma_pkg::FAST_LEN)),
    .recip(tsma_pkg::FAST_RECIP), .quot(fast_q)
  );

  tsma_div u_div_mid (
    .clk(clk), .en(div_en), .x(mid_sum), .divisor(LW'(tsma_pkg::MID_LEN)),
    .recip(tsma_pkg::MID_RECIP), .quot(mid_q)
  );

  tsma_div u_div_slow (
    .clk(clk), .en(div_en), .x(slow_sum), .divisor(LW'(tsma_pkg::SLOW_LEN)),
    .recip(tsma_pkg::SLOW_RECIP), .quot(slow_q)
  );

  // Stage 5 payload
  logic          s5_signal;
  logic [PW-1:0] s5_marker;
  win_t          s5_ok;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_signal <= s4_signal;
      s5_marker <= s4_marker;
      s5_ok     <= s4_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold while the receiver stalls
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en6) begin
      fast_average <= s5_ok.fast ? fast_q : '0;
      mid_average  <= s5_ok.mid  ? mid_q  : '0;
      slow_average <= s5_ok.slow ? slow_q : '0;
      buy_signal   <= s5_signal;
      marker_price <= s5_marker;
    end
  end

endmodule

/* rtl/tsma_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsma_checker: port-level checks of the alignment signal block
// Watches reset behavior, output stalls, the buy flag sequence and the marker price.
// ----------------------------------------------------------------------------
module tsma_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [tsma_pkg::PRICE_W-1:0]     slow_average,
  input logic                             buy_signal,
  input logic [tsma_pkg::PRICE_W-1:0]     marker_price
);

  logic last_buy;

  // Track the buy flag of the last delivered item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_buy <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_buy <= buy_signal;
    end
  end

  // Reset empties the pipeline and opens the input
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(buy_signal)
      && $stable(marker_price) && $stable(slow_average))
    else $error("stalled result changed");

  // No marker without a buy flag
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !buy_signal |-> marker_price == '0)
    else $error("marker price without buy flag");

  // A buy flag never repeats on the next bar
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_buy |-> !buy_signal)
    else $error("buy flag on two bars in a row");

endmodule

bind triple_sma_alignment_signal_top tsma_checker u_checker (.*);
